### rtl/prfir_pkg.sv
// ----------------------------------------------------------------------------
// prfir_pkg
// Shared types and constants for the polyphase rational resampling FIR.
// ----------------------------------------------------------------------------
package prfir_pkg;

  localparam int MAX_TAPS      = 64;
  localparam int MAX_RATE      = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int TAP_FRAC_BITS = 15;

  localparam int TAP_AW  = $clog2(MAX_TAPS);      // tap / history address
  localparam int CNT_W   = TAP_AW + 1;            // tap count, holds MAX_TAPS
  localparam int RATE_W  = 5;                     // L and M registers
  localparam int PH_W    = $clog2(MAX_RATE);      // phase counters
  localparam int PROD_W  = 2 * SAMPLE_BITS;
  localparam int ACC_W   = PROD_W + TAP_AW;
  localparam int CFG_AW  = 2;

  // opcodes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_TAP  = 1'b1;

  // register indexes
  localparam logic [CFG_AW-1:0] CFG_TAP_COUNT = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_INTERP    = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_DECIM     = 2'd2;

  // tap 0 after reset: unity saturated to Q15
  localparam logic signed [SAMPLE_BITS-1:0] TAP0_RESET =
      SAMPLE_BITS'((2 ** (SAMPLE_BITS - 1)) - 1);

  localparam logic signed [ACC_W-1:0] SAT_HI =
      ACC_W'((2 ** (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

  typedef struct packed {
    logic                          opcode;
    logic signed [SAMPLE_BITS-1:0] sample_in;
    logic [TAP_AW-1:0]             tap_index;
    logic signed [SAMPLE_BITS-1:0] tap_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_out;
    logic                          last_phase;
  } out_item_t;

  typedef struct packed {
    logic clear;   // zero the accumulator
    logic issue;   // a product request enters the pipe
  } mac_ctrl_t;

endpackage

### rtl/prfir_ram.sv
// ----------------------------------------------------------------------------
// prfir_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module prfir_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/prfir_mac.sv
// ----------------------------------------------------------------------------
// prfir_mac
// Shared multiply-accumulate: product register, accumulator, Q15 scale and
// saturation of the running sum.
// ----------------------------------------------------------------------------
module prfir_mac (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  prfir_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [prfir_pkg::SAMPLE_BITS-1:0] tap_i,
  input  logic signed [prfir_pkg::SAMPLE_BITS-1:0] smp_i,
  output logic                                    busy_o,
  output logic signed [prfir_pkg::SAMPLE_BITS-1:0] result_o
);

  logic                                  rd_vld_q;   // operands on tap_i/smp_i
  logic                                  prod_vld_q;
  logic signed [prfir_pkg::PROD_W-1:0]   prod_q;
  logic signed [prfir_pkg::ACC_W-1:0]    acc_q;
  logic signed [prfir_pkg::ACC_W-1:0]    scaled;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      prod_vld_q <= 1'b0;
    end else begin
      rd_vld_q   <= ctrl_i.issue;
      prod_vld_q <= rd_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_vld_q) begin
      prod_q <= prfir_pkg::PROD_W'(tap_i) * prfir_pkg::PROD_W'(smp_i);
    end
    if (ctrl_i.clear) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + prfir_pkg::ACC_W'(prod_q);
    end
  end

  // arithmetic shift floors toward minus infinity
  assign scaled = acc_q >>> prfir_pkg::TAP_FRAC_BITS;

  always_comb begin
    if (scaled > prfir_pkg::SAT_HI) begin
      result_o = prfir_pkg::SAT_HI[prfir_pkg::SAMPLE_BITS-1:0];
    end else if (scaled < prfir_pkg::SAT_LO) begin
      result_o = prfir_pkg::SAT_LO[prfir_pkg::SAMPLE_BITS-1:0];
    end else begin
      result_o = scaled[prfir_pkg::SAMPLE_BITS-1:0];
    end
  end

  assign busy_o = rd_vld_q | prod_vld_q;

endmodule

### rtl/polyphase_rational_resampling_fir.sv
// ----------------------------------------------------------------------------
// polyphase_rational_resampling_fir
// Interpolate-by-L, decimate-by-M polyphase FIR with one shared MAC.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_stall   | in_item_i  (opcode, sample, tap)
//  out     | output    | out_valid/out_stall | out_item_o (sample_out, last_phase)
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index_i, cfg_data_i
//
//  Tap writes and pushes that emit nothing leave the sequencer idle.
//  An emitting push runs all L phases: each phase issues its products one per cycle
//  into the shared MAC, then waits out the RAM read and product stages before the
//  result register is written; a phase with no tap below T issues no products.
//  A stalled output holds the sequencer at the end of the next phase.
//  cfg_ready is low while a run is in progress.
//  No clearing pass after reset; per-entry valid bits give the reset contents.
// ----------------------------------------------------------------------------
module polyphase_rational_resampling_fir (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  prfir_pkg::in_item_t                  in_item_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output prfir_pkg::out_item_t                 out_item_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [prfir_pkg::CFG_AW-1:0]         cfg_index_i,
  input  logic [prfir_pkg::CNT_W-1:0]          cfg_data_i
);

  localparam int AW  = prfir_pkg::TAP_AW;
  localparam int CW  = prfir_pkg::CNT_W;
  localparam int RW  = prfir_pkg::RATE_W;
  localparam int PW  = prfir_pkg::PH_W;
  localparam int SW  = prfir_pkg::SAMPLE_BITS;
  localparam int MW  = CW + RW - 1;   // warm-up product width

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]     state_q, state_d;
  logic [CW-1:0]  tap_cnt_q;
  logic [RW-1:0]  interp_q, decim_q;
  logic [PW-1:0]  j_q, j_d;
  logic [CW-1:0]  i_q, i_d;
  logic [AW-1:0]  k_q, k_d;
  logic [AW-1:0]  warm_q, warm_d;
  logic [PW-1:0]  dph_q, dph_d;
  logic [AW-1:0]  wp_q, wp_d;
  logic           out_valid_q, out_valid_d;
  prfir_pkg::out_item_t out_q, out_d;

  logic [prfir_pkg::MAX_TAPS-1:0] tap_vld_q, hist_vld_q;
  logic           tap_hit_q, tap_zero_q, hist_hit_q;

  logic           in_accept, push, tap_wr, cfg_we, cfg_hit;
  logic [CW-1:0]  tc_clamp;
  logic [RW-1:0]  rate_clamp;
  logic [CW-1:0]  warm_p1;
  logic [MW-1:0]  warm_prod;
  logic           in_warm;
  logic [PW-1:0]  ph;
  logic [RW-1:0]  ph_nxt;
  logic           emit;
  logic [CW-1:0]  i_nxt;
  logic           last, out_free;

  logic [AW-1:0]  hist_waddr, hist_raddr;
  logic [SW-1:0]  tap_rd, hist_rd;
  logic signed [SW-1:0] tap_val, hist_val, mac_result;
  logic           mac_busy;
  prfir_pkg::mac_ctrl_t mac_ctrl;

  // --------------------------------------------------------------------------
  // handshakes
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign push        = in_accept && (in_item_i.opcode == prfir_pkg::OP_PUSH);
  assign tap_wr      = in_accept && (in_item_i.opcode == prfir_pkg::OP_TAP);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_we && ((cfg_index_i == prfir_pkg::CFG_TAP_COUNT) ||
                                  (cfg_index_i == prfir_pkg::CFG_INTERP) ||
                                  (cfg_index_i == prfir_pkg::CFG_DECIM));

  // zero acts as one, oversize acts as the maximum (rates use only the low RW bits)
  always_comb begin
    if (cfg_data_i == '0) begin
      tc_clamp = CW'(1);
    end else if (cfg_data_i > CW'(prfir_pkg::MAX_TAPS)) begin
      tc_clamp = CW'(prfir_pkg::MAX_TAPS);
    end else begin
      tc_clamp = cfg_data_i;
    end
    if (cfg_data_i[RW-1:0] == '0) begin
      rate_clamp = RW'(1);
    end else if (cfg_data_i[RW-1:0] > RW'(prfir_pkg::MAX_RATE)) begin
      rate_clamp = RW'(prfir_pkg::MAX_RATE);
    end else begin
      rate_clamp = cfg_data_i[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_cnt_q <= CW'(1);
      interp_q  <= RW'(1);
      decim_q   <= RW'(1);
    end else if (cfg_we) begin
      case (cfg_index_i)
        prfir_pkg::CFG_TAP_COUNT: tap_cnt_q <= tc_clamp;
        prfir_pkg::CFG_INTERP:    interp_q  <= rate_clamp;
        prfir_pkg::CFG_DECIM:     decim_q   <= rate_clamp;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // warm-up: still warming while T > (count+1)*L, i.e. count+1 < ceil(T/L)
  assign warm_p1   = {1'b0, warm_q} + CW'(1);
  assign warm_prod = MW'(warm_p1) * MW'(interp_q);
  assign in_warm   = (MW'(tap_cnt_q) > warm_prod);

  assign ph     = ({1'b0, dph_q} >= decim_q) ? '0 : dph_q;
  assign emit   = (ph == '0);
  assign ph_nxt = {1'b0, ph} + RW'(1);

  assign i_nxt    = i_q + CW'(interp_q);
  assign last     = ({1'b0, j_q} == (interp_q - RW'(1)));
  assign out_free = !out_valid_q || !out_stall_i;

  // --------------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_d     = state_q;
    j_d         = j_q;
    i_d         = i_q;
    k_d         = k_q;
    warm_d      = warm_q;
    dph_d       = dph_q;
    wp_d        = wp_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mac_ctrl    = '0;

    case (state_q)
      ST_IDLE: begin
        if (push) begin
          wp_d = wp_q + AW'(1);
          if (in_warm) begin
            warm_d = warm_q + AW'(1);
          end else begin
            dph_d = (ph_nxt >= decim_q) ? '0 : ph_nxt[PW-1:0];
            if (emit) begin
              state_d        = ST_ISSUE;
              j_d            = '0;
              i_d            = '0;
              k_d            = '0;
              mac_ctrl.clear = 1'b1;
            end
          end
        end
      end
      ST_ISSUE: begin
        // phase j walks taps j, j+L, j+2L, ... below T
        if (i_q < tap_cnt_q) begin
          mac_ctrl.issue = 1'b1;
          i_d = i_nxt;
          k_d = k_q + AW'(1);
          if (i_nxt >= tap_cnt_q) begin
            state_d = ST_DRAIN;
          end
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!mac_busy && out_free) begin
          out_valid_d      = 1'b1;
          out_d.sample_out = mac_result;
          out_d.last_phase = last;
          if (last) begin
            state_d = ST_IDLE;
          end else begin
            state_d        = ST_ISSUE;
            j_d            = j_q + PW'(1);
            i_d            = {{(CW-PW){1'b0}}, j_q} + CW'(1);
            k_d            = '0;
            mac_ctrl.clear = 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // register writes restart warm-up and decimation
    if (cfg_hit) begin
      warm_d = '0;
      dph_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= '0;
      i_q         <= '0;
      k_q         <= '0;
      warm_q      <= '0;
      dph_q       <= '0;
      wp_q        <= '0;
      out_valid_q <= 1'b0;
      tap_vld_q   <= '0;
      hist_vld_q  <= '0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      i_q         <= i_d;
      k_q         <= k_d;
      warm_q      <= warm_d;
      dph_q       <= dph_d;
      wp_q        <= wp_d;
      out_valid_q <= out_valid_d;
      if (tap_wr) begin
        tap_vld_q[in_item_i.tap_index] <= 1'b1;
      end
      if (push) begin
        hist_vld_q[hist_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // --------------------------------------------------------------------------
  // storage: taps by index, history as a ring with wp_q on the newest sample
  assign hist_waddr = wp_q + AW'(1);
  assign hist_raddr = wp_q - k_q;

  prfir_ram #(
    .DEPTH (prfir_pkg::MAX_TAPS),
    .WIDTH (SW)
  ) u_tap_ram (
    .clk_i   (clk_i),
    .we_i    (tap_wr),
    .waddr_i (in_item_i.tap_index),
    .wdata_i (in_item_i.tap_value),
    .raddr_i (i_q[AW-1:0]),
    .rdata_o (tap_rd)
  );

  prfir_ram #(
    .DEPTH (prfir_pkg::MAX_TAPS),
    .WIDTH (SW)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (push),
    .waddr_i (hist_waddr),
    .wdata_i (in_item_i.sample_in),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rd)
  );

  // entries never written read as their reset contents
  always_ff @(posedge clk_i) begin
    tap_hit_q  <= tap_vld_q[i_q[AW-1:0]];
    tap_zero_q <= (i_q[AW-1:0] == '0);
    hist_hit_q <= hist_vld_q[hist_raddr];
  end

  always_comb begin
    if (tap_hit_q) begin
      tap_val = tap_rd;
    end else if (tap_zero_q) begin
      tap_val = prfir_pkg::TAP0_RESET;
    end else begin
      tap_val = '0;
    end
    hist_val = hist_hit_q ? hist_rd : '0;
  end

  prfir_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .tap_i    (tap_val),
    .smp_i    (hist_val),
    .busy_o   (mac_busy),
    .result_o (mac_result)
  );

  // --------------------------------------------------------------------------
  // assertions
  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_IDLE) |-> !mac_busy)
    else $error("MAC pipe busy while sequencer idle");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q == ST_DRAIN && !mac_busy && out_free && last) |=>
      (state_q == ST_IDLE && out_valid_q && out_q.last_phase))
    else $error("last phase did not end the run");

  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (state_q != ST_IDLE) |-> ({1'b0, j_q} < interp_q))
    else $error("phase counter beyond interpolation factor");

endmodule
